/* src/erc_pkg.sv */
`default_nettype none

package erc_pkg;

    localparam int unsigned NUM_CELLS = 9;

    localparam logic [2:0] REG_ROTOR_CHOICE    = 3'd0;
    localparam logic [2:0] REG_RING_SETTINGS   = 3'd1;
    localparam logic [2:0] REG_START_POSITIONS = 3'd2;
    localparam logic [2:0] REG_PLUG_LOW        = 3'd3;
    localparam logic [2:0] REG_PLUG_MID        = 3'd4;
    localparam logic [2:0] REG_PLUG_HIGH       = 3'd5;

    localparam logic [1:0] SLOT_RIGHT  = 2'd0;
    localparam logic [1:0] SLOT_MIDDLE = 2'd1;
    localparam logic [1:0] SLOT_LEFT   = 2'd2;

    typedef enum logic [1:0] {
        OP_PLUG    = 2'd0,
        OP_FWD     = 2'd1,
        OP_INV     = 2'd2,
        OP_REFLECT = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t   op;
        logic [1:0] slot;
    } cell_ctl_t;

    typedef struct packed {
        logic [8:0]        rotor_choice;
        logic [14:0]       ring_settings;
        logic [25:0][4:0]  plug;
    } cfg_t;

    typedef struct packed {
        logic             restart;
        logic [4:0]       letter;
        logic [2:0][4:0]  pos;
    } token_t;

    // plugboard, three rotors, reflector, three inverse rotors, plugboard
    localparam cell_ctl_t CELL_CTL [NUM_CELLS] = '{
        '{OP_PLUG,    SLOT_RIGHT},
        '{OP_FWD,     SLOT_RIGHT},
        '{OP_FWD,     SLOT_MIDDLE},
        '{OP_FWD,     SLOT_LEFT},
        '{OP_REFLECT, SLOT_RIGHT},
        '{OP_INV,     SLOT_LEFT},
        '{OP_INV,     SLOT_MIDDLE},
        '{OP_INV,     SLOT_RIGHT},
        '{OP_PLUG,    SLOT_RIGHT}
    };

    localparam logic [4:0] NOTCH [5] = '{5'd16, 5'd4, 5'd21, 5'd9, 5'd25};

    localparam logic [4:0] WIRE_FWD [5][26] = '{
        '{5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19,
          5'd14, 5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17,
          5'd2, 5'd9},
        '{5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7,
          5'd22, 5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21,
          5'd14, 5'd4},
        '{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21,
          5'd25, 5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18,
          5'd16, 5'd14},
        '{5'd4, 5'd18, 5'd14, 5'd21, 5'd15, 5'd25, 5'd9, 5'd0, 5'd24, 5'd16, 5'd20, 5'd8,
          5'd17, 5'd7, 5'd23, 5'd11, 5'd13, 5'd5, 5'd19, 5'd6, 5'd10, 5'd3, 5'd2, 5'd12,
          5'd22, 5'd1},
        '{5'd21, 5'd25, 5'd1, 5'd17, 5'd6, 5'd8, 5'd19, 5'd24, 5'd20, 5'd15, 5'd18, 5'd3,
          5'd13, 5'd7, 5'd11, 5'd23, 5'd0, 5'd22, 5'd12, 5'd9, 5'd16, 5'd14, 5'd5, 5'd4,
          5'd2, 5'd10}
    };

    localparam logic [4:0] WIRE_INV [5][26] = '{
        '{5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4,
          5'd2, 5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16,
          5'd14, 5'd9},
        '{5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10,
          5'd14, 5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8,
          5'd21, 5'd18},
        '{5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5,
          5'd21, 5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10,
          5'd14, 5'd12},
        '{5'd7, 5'd25, 5'd22, 5'd21, 5'd0, 5'd17, 5'd19, 5'd13, 5'd11, 5'd6, 5'd20, 5'd15,
          5'd23, 5'd16, 5'd2, 5'd4, 5'd9, 5'd12, 5'd1, 5'd18, 5'd10, 5'd3, 5'd24, 5'd14,
          5'd8, 5'd5},
        '{5'd16, 5'd2, 5'd24, 5'd11, 5'd23, 5'd22, 5'd4, 5'd13, 5'd5, 5'd19, 5'd25, 5'd14,
          5'd18, 5'd12, 5'd21, 5'd9, 5'd20, 5'd3, 5'd10, 5'd6, 5'd8, 5'd0, 5'd17, 5'd15,
          5'd7, 5'd1}
    };

    localparam logic [4:0] REFLECT_B [26] = '{
        5'd24, 5'd17, 5'd20, 5'd7, 5'd16, 5'd18, 5'd11, 5'd3, 5'd15, 5'd23, 5'd13, 5'd6,
        5'd14, 5'd10, 5'd12, 5'd8, 5'd4, 5'd1, 5'd5, 5'd25, 5'd2, 5'd22, 5'd21, 5'd9,
        5'd0, 5'd19
    };

    function automatic logic [4:0] add26(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 6'd26) ? 5'(s - 6'd26) : s[4:0];
    endfunction

    function automatic logic [4:0] sub26(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        s = {1'b0, a} + 6'd26 - {1'b0, b};
        return (a >= b) ? 5'(a - b) : s[4:0];
    endfunction

    function automatic logic [4:0] red26(input logic [4:0] v);
        return (v >= 5'd26) ? 5'(v - 5'd26) : v;
    endfunction

    function automatic logic [4:0] inc26(input logic [4:0] v);
        return (v == 5'd25) ? 5'd0 : 5'(v + 5'd1);
    endfunction

    function automatic logic [4:0] sat25(input logic [4:0] v);
        return (v > 5'd25) ? 5'd25 : v;
    endfunction

    function automatic logic [2:0] clamp_code(input logic [2:0] c);
        return (c > 3'd4) ? 3'd4 : c;
    endfunction

    function automatic logic [2:0] slot_code(input logic [8:0] rc, input logic [1:0] slot);
        logic [2:0] c;
        case (slot)
            SLOT_RIGHT:  c = rc[2:0];
            SLOT_MIDDLE: c = rc[5:3];
            SLOT_LEFT:   c = rc[8:6];
            default:     c = rc[2:0];
        endcase
        return clamp_code(c);
    endfunction

    function automatic logic [4:0] slot_ring(input logic [14:0] rs, input logic [1:0] slot);
        logic [4:0] r;
        case (slot)
            SLOT_RIGHT:  r = rs[4:0];
            SLOT_MIDDLE: r = rs[9:5];
            SLOT_LEFT:   r = rs[14:10];
            default:     r = rs[4:0];
        endcase
        return sat25(r);
    endfunction

endpackage

`default_nettype wire

/* src/erc_in_if.sv */
`default_nettype none

interface erc_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [4:0] letter;

    modport source (output valid, output action, output letter, input ready);
    modport sink (input valid, input action, input letter, output ready);
endinterface

`default_nettype wire

/* src/erc_out_if.sv */
`default_nettype none

interface erc_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] out_letter;
    logic [4:0] right_position;
    logic [4:0] middle_position;
    logic [4:0] left_position;

    modport source (
        output valid, output out_letter, output right_position,
        output middle_position, output left_position, input ready
    );
    modport sink (
        input valid, input out_letter, input right_position,
        input middle_position, input left_position, output ready
    );
endinterface

`default_nettype wire

/* src/enigma_rotor_cipher_core.sv */
`default_nettype none

// Three-rotor M3-style Enigma (rotors I-V, reflector B) with a fully pipelined letter path.
// One item is accepted per clock while item_out.ready does not stall; each item passes
// one stepping stage, then nine cells (plugboard, three rotors, reflector, three inverse
// rotors, plugboard), and results leave in order. The rate is set by the stepping stage,
// which updates the three rotor positions once per accepted item. Action 1 reloads the
// positions from start_positions and returns letter zero. Registers sit on a 64-bit APB
// port at byte address 8*i: rotor_choice, ring_settings, start_positions, plug_low,
// plug_mid, plug_high; change them only while no item is in flight.
module enigma_rotor_cipher_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    erc_in_if.sink            item_in,
    erc_out_if.source         item_out,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    logic [8:0]   rotor_choice_reg;
    logic [14:0]  ring_settings_reg;
    logic [14:0]  start_positions_reg;
    logic [44:0]  plug_low_reg;
    logic [44:0]  plug_mid_reg;
    logic [39:0]  plug_high_reg;
    logic         wr_en;
    logic [2:0]   reg_idx;
    logic         addr_ok;

    erc_pkg::cfg_t    cfg;
    logic             valid [erc_pkg::NUM_CELLS + 1];
    logic             ready [erc_pkg::NUM_CELLS + 1];
    erc_pkg::token_t  tok   [erc_pkg::NUM_CELLS + 1];

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign addr_ok = (paddr[2:0] == 3'd0);
    assign wr_en   = psel && penable && pwrite && addr_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotor_choice_reg    <= 9'd10;
            ring_settings_reg   <= '0;
            start_positions_reg <= '0;
            plug_low_reg        <= '0;
            plug_mid_reg        <= '0;
            plug_high_reg       <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                erc_pkg::REG_ROTOR_CHOICE:    rotor_choice_reg    <= pwdata[8:0];
                erc_pkg::REG_RING_SETTINGS:   ring_settings_reg   <= pwdata[14:0];
                erc_pkg::REG_START_POSITIONS: start_positions_reg <= pwdata[14:0];
                erc_pkg::REG_PLUG_LOW:        plug_low_reg        <= pwdata[44:0];
                erc_pkg::REG_PLUG_MID:        plug_mid_reg        <= pwdata[44:0];
                erc_pkg::REG_PLUG_HIGH:       plug_high_reg       <= pwdata[39:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (addr_ok)
        begin
            case (reg_idx)
                erc_pkg::REG_ROTOR_CHOICE:    prdata = 64'(rotor_choice_reg);
                erc_pkg::REG_RING_SETTINGS:   prdata = 64'(ring_settings_reg);
                erc_pkg::REG_START_POSITIONS: prdata = 64'(start_positions_reg);
                erc_pkg::REG_PLUG_LOW:        prdata = 64'(plug_low_reg);
                erc_pkg::REG_PLUG_MID:        prdata = 64'(plug_mid_reg);
                erc_pkg::REG_PLUG_HIGH:       prdata = 64'(plug_high_reg);
                default:                      prdata = '0;
            endcase
        end
    end

    assign cfg.rotor_choice  = rotor_choice_reg;
    assign cfg.ring_settings = ring_settings_reg;
    assign cfg.plug          = {plug_high_reg, plug_mid_reg, plug_low_reg};

    erc_stepper u_stepper (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_in         (item_in),
        .rotor_choice    (rotor_choice_reg),
        .start_positions (start_positions_reg),
        .dn_valid        (valid[0]),
        .dn_tok          (tok[0]),
        .dn_ready        (ready[0])
    );

    for (genvar k = 0; k < erc_pkg::NUM_CELLS; k++)
    begin : g_cell
        erc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (erc_pkg::CELL_CTL[k]),
            .cfg      (cfg),
            .up_valid (valid[k]),
            .up_tok   (tok[k]),
            .up_ready (ready[k]),
            .dn_valid (valid[k + 1]),
            .dn_tok   (tok[k + 1]),
            .dn_ready (ready[k + 1])
        );
    end

    assign ready[erc_pkg::NUM_CELLS] = item_out.ready;
    assign item_out.valid            = valid[erc_pkg::NUM_CELLS];
    assign item_out.out_letter       = tok[erc_pkg::NUM_CELLS].restart ?
                                       5'd0 : tok[erc_pkg::NUM_CELLS].letter;
    assign item_out.right_position   = tok[erc_pkg::NUM_CELLS].pos[0];
    assign item_out.middle_position  = tok[erc_pkg::NUM_CELLS].pos[1];
    assign item_out.left_position    = tok[erc_pkg::NUM_CELLS].pos[2];

endmodule

`default_nettype wire

/* src/erc_stepper.sv */
`default_nettype none

module erc_stepper (
    input  wire logic              clk,
    input  wire logic              rst_n,
    erc_in_if.sink                 item_in,
    input  wire logic [8:0]        rotor_choice,
    input  wire logic [14:0]       start_positions,
    output logic                   dn_valid,
    output erc_pkg::token_t        dn_tok,
    input  wire logic              dn_ready
);

    logic [2:0][4:0]  pos_reg;
    logic [2:0][4:0]  pos_next;
    logic             valid_reg;
    erc_pkg::token_t  tok_reg;
    erc_pkg::token_t  tok_next;
    logic             accept;
    logic [2:0]       code_r;
    logic [2:0]       code_m;

    assign item_in.ready = !valid_reg || dn_ready;
    assign accept        = item_in.valid && item_in.ready;
    assign code_r        = erc_pkg::slot_code(rotor_choice, erc_pkg::SLOT_RIGHT);
    assign code_m        = erc_pkg::slot_code(rotor_choice, erc_pkg::SLOT_MIDDLE);

    // reload on action, else step the rotors with double stepping of the middle rotor
    always_comb
    begin
        pos_next = pos_reg;
        if (item_in.action)
        begin
            pos_next[0] = erc_pkg::sat25(start_positions[4:0]);
            pos_next[1] = erc_pkg::sat25(start_positions[9:5]);
            pos_next[2] = erc_pkg::sat25(start_positions[14:10]);
        end
        else
        begin
            if (pos_reg[1] == erc_pkg::NOTCH[code_m])
            begin
                pos_next[1] = erc_pkg::inc26(pos_reg[1]);
                pos_next[2] = erc_pkg::inc26(pos_reg[2]);
            end
            else if (pos_reg[0] == erc_pkg::NOTCH[code_r])
            begin
                pos_next[1] = erc_pkg::inc26(pos_reg[1]);
            end
            pos_next[0] = erc_pkg::inc26(pos_reg[0]);
        end
        tok_next.restart = item_in.action;
        tok_next.letter  = item_in.action ? 5'd0 : erc_pkg::red26(item_in.letter);
        tok_next.pos     = pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg <= pos_next;
            end
            if (item_in.ready)
            begin
                valid_reg <= item_in.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok_reg <= tok_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_tok   = tok_reg;

endmodule

`default_nettype wire

/* src/erc_cell.sv */
`default_nettype none

module erc_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire erc_pkg::cell_ctl_t   ctl,
    input  wire erc_pkg::cfg_t        cfg,
    input  wire logic                 up_valid,
    input  wire erc_pkg::token_t      up_tok,
    output logic                      up_ready,
    output logic                      dn_valid,
    output erc_pkg::token_t           dn_tok,
    input  wire logic                 dn_ready
);

    logic             valid_reg;
    erc_pkg::token_t  tok_reg;
    erc_pkg::token_t  tok_next;
    logic [2:0]       code;
    logic [4:0]       delta;
    logic [4:0]       shifted;
    logic [4:0]       mapped;

    assign up_ready = !valid_reg || dn_ready;
    assign code     = erc_pkg::slot_code(cfg.rotor_choice, ctl.slot);
    assign delta    = erc_pkg::sub26(up_tok.pos[ctl.slot],
                                     erc_pkg::slot_ring(cfg.ring_settings, ctl.slot));
    assign shifted  = erc_pkg::add26(up_tok.letter, delta);

    always_comb
    begin
        case (ctl.op)
            erc_pkg::OP_PLUG:
                mapped = erc_pkg::add26(up_tok.letter,
                                        erc_pkg::red26(cfg.plug[up_tok.letter]));
            erc_pkg::OP_FWD:
                mapped = erc_pkg::sub26(erc_pkg::WIRE_FWD[code][shifted], delta);
            erc_pkg::OP_INV:
                mapped = erc_pkg::sub26(erc_pkg::WIRE_INV[code][shifted], delta);
            erc_pkg::OP_REFLECT:
                mapped = erc_pkg::REFLECT_B[up_tok.letter];
            default:
                mapped = up_tok.letter;
        endcase
        tok_next        = up_tok;
        tok_next.letter = mapped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            tok_reg <= tok_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_tok   = tok_reg;

endmodule

`default_nettype wire
